>>> hdl/mr61_pkg.sv
// shared types and constants for the 128-by-61 modular reduction pipeline
// no dependencies
`timescale 1ns / 1ps

package mr61_pkg;

    localparam int MODULUS_WIDTH = 61;
    localparam int WORD_WIDTH    = 64;

    localparam logic [MODULUS_WIDTH-1:0] MODULUS_RESET = {MODULUS_WIDTH{1'b1}};

    // control that travels with each request down the pipeline
    typedef struct packed {
        logic valid;
        logic sat;
    } mr_ctrl_t;

endpackage

>>> hdl/mr61_stage.sv
// one restoring step of the quotient search: trial subtract of modulus << BIT_POS
// depends on mr61_pkg
`timescale 1ns / 1ps

module mr61_stage
    import mr61_pkg::*;
#(
    parameter int RES_WIDTH = 122,
    parameter int BIT_POS   = 0
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [MODULUS_WIDTH-1:0] modulus,
    input  mr_ctrl_t                 ctrl_in,
    input  logic [RES_WIDTH-1:0]     res_in,
    output mr_ctrl_t                 ctrl_out,
    output logic [RES_WIDTH-1:0]     res_out
);

    logic [RES_WIDTH-1:0] shifted;
    logic [RES_WIDTH:0]   diff;
    logic                 take;

    mr_ctrl_t             ctrl_reg;
    logic [RES_WIDTH-1:0] res_reg;
    logic [RES_WIDTH-1:0] res_next;

    always_comb
    begin
        shifted  = RES_WIDTH'(modulus) << BIT_POS;
        diff     = {1'b0, res_in} - {1'b0, shifted};
        // no borrow means the trial bit fits
        take     = !diff[RES_WIDTH] && !ctrl_in.sat;
        res_next = take ? diff[RES_WIDTH-1:0] : res_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign ctrl_out = ctrl_reg;
    assign res_out  = res_reg;

endmodule

>>> hdl/modular_reduction_128_by_61.sv
// top level of the 128-bit by 61-bit modular reduction pipeline
// depends on mr61_pkg and mr61_stage
`timescale 1ns / 1ps
//
// channel   | ports                              | handshake
// ----------+------------------------------------+-----------------------------
// request   | value_high, value_low              | taken when start && !busy
// result    | remainder                          | one cycle, marked by done
// config    | cfg_wdata                          | written when cfg_we is high
//
// one request enters every cycle; it passes the registered entry stage, then every step
// pipeline depth is set by the chain of restoring steps, one quotient bit per stage,
// each stage a single wide subtract
// busy is tied low: the result side cannot stall, so nothing ever backs up
// reset clears the valid bits of all stages and loads the modulus with 2^61-1
// no clearing pass and no stored configuration besides the modulus

module modular_reduction_128_by_61
    import mr61_pkg::*;
#(
    parameter int QUOTIENT_BITS = 61
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [WORD_WIDTH-1:0]    value_high,
    input  logic [WORD_WIDTH-1:0]    value_low,
    output logic                     done,
    output logic [WORD_WIDTH-1:0]    remainder,
    input  logic                     cfg_we,
    input  logic [MODULUS_WIDTH-1:0] cfg_wdata
);

    // residual width: once the top quotient fails, value < modulus * 2^QUOTIENT_BITS
    localparam int RES_W = MODULUS_WIDTH + QUOTIENT_BITS;
    localparam int PAD_W = 2 * WORD_WIDTH - RES_W;

    logic [MODULUS_WIDTH-1:0] modulus_reg;

    // entry stage signals
    logic [RES_W-1:0]          top_prod;
    logic [2*WORD_WIDTH-1:0]   value_full;
    logic                      top_fits;
    logic [WORD_WIDTH-1:0]     sat_rem;
    mr_ctrl_t                  ctrl0_reg;
    mr_ctrl_t                  ctrl0_next;
    logic [RES_W-1:0]          res0_reg;
    logic [RES_W-1:0]          res0_next;

    // pipeline taps, index 0 is the entry stage output
    mr_ctrl_t                  ctrl_s [0:QUOTIENT_BITS];
    logic [RES_W-1:0]          res_s  [0:QUOTIENT_BITS];

    // modulus register; the user must write it only while the pipeline is empty, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_wdata;
        end
    end

    assign busy = 1'b0;

    // entry stage: test the saturated quotient 2^QUOTIENT_BITS
    always_comb
    begin
        top_prod         = RES_W'(modulus_reg) << QUOTIENT_BITS;
        value_full       = {value_high, value_low};
        top_fits         = {{PAD_W{1'b0}}, top_prod} <= value_full;
        // saturated case: wrapped difference, later stages leave it alone
        sat_rem          = value_low - top_prod[WORD_WIDTH-1:0];
        res0_next        = top_fits ? RES_W'(sat_rem) : value_full[RES_W-1:0];
        ctrl0_next.valid = start && !busy;
        ctrl0_next.sat   = top_fits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl0_reg <= '0;
        end
        else
        begin
            ctrl0_reg <= ctrl0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res0_reg <= res0_next;
    end

    assign ctrl_s[0] = ctrl0_reg;
    assign res_s[0]  = res0_reg;

    // one restoring step per quotient bit, most significant first
    for (genvar k = 0; k < QUOTIENT_BITS; k++)
    begin : g_step
        mr61_stage #(
            .RES_WIDTH (RES_W),
            .BIT_POS   (QUOTIENT_BITS - 1 - k)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .modulus  (modulus_reg),
            .ctrl_in  (ctrl_s[k]),
            .res_in   (res_s[k]),
            .ctrl_out (ctrl_s[k+1]),
            .res_out  (res_s[k+1])
        );
    end

    // residual after the last step is value - modulus * q
    assign done      = ctrl_s[QUOTIENT_BITS].valid;
    assign remainder = res_s[QUOTIENT_BITS][WORD_WIDTH-1:0];

`ifndef ASSERT_OFF
    // every request yields a result after the full pipeline depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(QUOTIENT_BITS + 1) done)
        else $error("request did not produce a result on time");

    // no result without a request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, QUOTIENT_BITS + 1))
        else $error("result without a matching request");

    // the saturation flag rides unchanged from entry to exit
    a_sat_carried: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ctrl_s[QUOTIENT_BITS].sat == $past(ctrl_s[0].sat, QUOTIENT_BITS))
        else $error("saturation flag corrupted in pipeline");

    // saturated items keep a 64-bit residual through all steps
    a_sat_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        done && ctrl_s[QUOTIENT_BITS].sat |->
            res_s[QUOTIENT_BITS][RES_W-1:WORD_WIDTH] == '0)
        else $error("saturated residual modified by a search step");
`endif

endmodule
